// File: rtl/buffer_frame_clock_replacer_macros.svh
// Assertion macros for the frame replacer checker
`ifndef BUFFER_FRAME_CLOCK_REPLACER_MACROS_SVH
`define BUFFER_FRAME_CLOCK_REPLACER_MACROS_SVH
// implication checked at every clock, off during reset
`define BFCR_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication, off during reset
`define BFCR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// File: rtl/bfcr_pkg.sv
// Shared types and constants for the frame replacer
package bfcr_pkg;
  localparam int NumFrames = 32;
  localparam int PinBits   = 8;
  localparam int FrameW    = $clog2(NumFrames);
  localparam int CountW    = 6;
  localparam int FileW     = 8;
  localparam int PageW     = 20;
  localparam logic [PinBits-1:0] PinMax = '1;

  localparam logic [1:0] ModeFetch   = 2'd0;
  localparam logic [1:0] ModeUnpin   = 2'd1;
  localparam logic [1:0] ModeNew     = 2'd2;
  localparam logic [1:0] ModeDispose = 2'd3;

  localparam logic [1:0] StatOk        = 2'd0;
  localparam logic [1:0] StatAllPinned = 2'd1;
  localparam logic [1:0] StatNotRes    = 2'd2;
  localparam logic [1:0] StatNotPinned = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE, ST_LOOKUP, ST_DECIDE, ST_SWEEP, ST_DONE
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic capture;   // latch request
    logic scan;      // register lookup result
    logic act;       // apply hit/unpin/dispose action or start sweep
    logic step;      // visit next frame
    logic fail;      // sweep found nothing
    logic emit;      // drive result strobe
  } ctrl_t;

  // datapath to controller
  typedef struct packed {
    logic need_sweep;  // request needs a victim
    logic taken;       // current visit took a frame
    logic last;        // visit budget spent
    logic hand_ok;     // hand lies within the active frames
  } stat_t;
endpackage

// File: rtl/bfcr_ctrl.sv
// Request sequencer for the frame replacer
module bfcr_ctrl import bfcr_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  start,
  input  stat_t st,
  output logic  busy,
  output ctrl_t cmd
);
  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (start && st.hand_ok) state_next = ST_LOOKUP;
      ST_LOOKUP: state_next = ST_DECIDE;
      ST_DECIDE: state_next = st.need_sweep ? ST_SWEEP : ST_DONE;
      ST_SWEEP:  if (st.taken || st.last) state_next = ST_DONE;
      ST_DONE:   state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    // hold off new words until the hand is back in range
    busy = (state != ST_IDLE) || !st.hand_ok;
    case (state)
      ST_IDLE:   cmd.capture = start && st.hand_ok;
      ST_LOOKUP: cmd.scan = 1'b1;
      ST_DECIDE: cmd.act = 1'b1;
      ST_SWEEP: begin
        cmd.step = 1'b1;
        cmd.fail = st.last && !st.taken;
      end
      ST_DONE:   cmd.emit = 1'b1;
      default:   cmd = '0;
    endcase
  end
endmodule

// File: rtl/bfcr_dp.sv
// Frame table, lookup and clock hand for the frame replacer
module bfcr_dp import bfcr_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  ctrl_t             cmd,
  output stat_t             st,
  input  logic              cfg_we,
  input  logic [CountW-1:0] cfg_data,
  input  logic [1:0]        mode,
  input  logic [FileW-1:0]  file_id,
  input  logic [PageW-1:0]  page_no,
  input  logic              set_dirty,
  output logic              done,
  output logic [1:0]        status,
  output logic [FrameW-1:0] frame,
  output logic              hit,
  output logic              need_read,
  output logic              write_back,
  output logic [FileW-1:0]  victim_file,
  output logic [PageW-1:0]  victim_page
);
  localparam int VisitW = FrameW + 2;

  logic [NumFrames-1:0] fvalid, fref, fdirty;
  logic [PinBits-1:0]   fpins [NumFrames];
  logic [FileW-1:0]     ffile [NumFrames];
  logic [PageW-1:0]     fpage [NumFrames];

  logic [CountW-1:0] frames_in_use;
  logic [FrameW-1:0] hand;
  logic [VisitW-1:0] visits;
  logic [1:0]        rmode;
  logic [FileW-1:0]  rfile;
  logic [PageW-1:0]  rpage;
  logic              rdirty;
  logic              found;
  logic [FrameW-1:0] fidx;

  logic [FrameW:0]   active;
  logic [FrameW-1:0] hand_nx;
  logic              match_any;
  logic [FrameW-1:0] match_idx;
  logic              can_take;

  always_comb begin
    if (frames_in_use == '0) active = (FrameW+1)'(1);
    else if (frames_in_use > CountW'(NumFrames)) active = (FrameW+1)'(NumFrames);
    else active = (FrameW+1)'(frames_in_use);
  end

  // wrap the hand within the active frames
  assign hand_nx = ((FrameW+1)'(hand) + 1'b1 >= active) ? '0 : hand + 1'b1;

  always_comb begin
    match_any = 1'b0;
    match_idx = '0;
    for (int i = NumFrames - 1; i >= 0; i--) begin
      if (fvalid[i] && ffile[i] == rfile && fpage[i] == rpage) begin
        match_any = 1'b1;
        match_idx = FrameW'(i);
      end
    end
  end

  assign can_take = !fvalid[hand_nx] || (!fref[hand_nx] && fpins[hand_nx] == '0);
  assign st.need_sweep = !found && (rmode == ModeFetch || rmode == ModeNew);
  assign st.taken = can_take;
  assign st.last  = (visits == VisitW'({active, 1'b0}) - 1'b1);
  assign st.hand_ok = ((FrameW+1)'(hand) < active);

  always_ff @(posedge clk) begin
    if (rst) begin
      frames_in_use <= CountW'(NumFrames);
      hand <= FrameW'(NumFrames - 1);
      fvalid <= '0;
      fref <= '0;
      fdirty <= '0;
      done <= 1'b0;
      for (int i = 0; i < NumFrames; i++) fpins[i] <= '0;
    end else begin
      done <= cmd.emit;
      if (cfg_we) begin
        frames_in_use <= cfg_data;
      end
      // after a count change, reduce the hand modulo the active frames
      if (!st.hand_ok) hand <= hand - FrameW'(active);
      if (cmd.capture) begin
        rmode <= mode;
        rfile <= file_id;
        rpage <= page_no;
        rdirty <= set_dirty;
        visits <= '0;
        status <= StatOk;
        frame <= '0;
        hit <= 1'b0;
        need_read <= 1'b0;
        write_back <= 1'b0;
        victim_file <= '0;
        victim_page <= '0;
      end
      if (cmd.scan) begin
        found <= match_any;
        fidx <= match_idx;
      end
      if (cmd.act && found) begin
        frame <= fidx;
        hit <= 1'b1;
        case (rmode)
          ModeFetch: begin
            fref[fidx] <= 1'b1;
            if (fpins[fidx] != PinMax) fpins[fidx] <= fpins[fidx] + 1'b1;
          end
          ModeUnpin: begin
            if (fpins[fidx] == '0) status <= StatNotPinned;
            else begin
              if (rdirty) fdirty[fidx] <= 1'b1;
              fpins[fidx] <= fpins[fidx] - 1'b1;
            end
          end
          ModeNew: begin
            fref[fidx] <= 1'b1;
            fdirty[fidx] <= 1'b0;
            fpins[fidx] <= PinBits'(1);
          end
          default: begin
            fvalid[fidx] <= 1'b0;
            fref[fidx] <= 1'b0;
            fdirty[fidx] <= 1'b0;
            fpins[fidx] <= '0;
          end
        endcase
      end
      if (cmd.act && !found && rmode == ModeUnpin) status <= StatNotRes;
      if (cmd.step) begin
        hand <= hand_nx;
        visits <= visits + 1'b1;
        if (can_take) begin
          if (fvalid[hand_nx] && fdirty[hand_nx]) begin
            write_back <= 1'b1;
            victim_file <= ffile[hand_nx];
            victim_page <= fpage[hand_nx];
          end
          fvalid[hand_nx] <= 1'b1;
          fref[hand_nx] <= 1'b1;
          fdirty[hand_nx] <= 1'b0;
          fpins[hand_nx] <= PinBits'(1);
          ffile[hand_nx] <= rfile;
          fpage[hand_nx] <= rpage;
          frame <= hand_nx;
          need_read <= (rmode == ModeFetch);
        end else if (fref[hand_nx]) begin
          fref[hand_nx] <= 1'b0;
        end
        if (cmd.fail) status <= StatAllPinned;
      end
    end
  end
endmodule

// File: rtl/buffer_frame_clock_replacer.sv
// From start to result strobe, a hit, unpin or dispose goes through the lookup,
// decide and done states; a fetch miss or a new page that is not resident also
// sweeps with the clock, one frame visited per cycle, at most twice the active
// frame count. One request at a time; busy stays high until the result strobe
// and after a frame count write while the hand wraps into range.
// Sync reset clears all frames, count 32, hand 31; done strobes one cycle, no stall.
module buffer_frame_clock_replacer import bfcr_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic              cfg_we,
  input  logic [CountW-1:0] cfg_data,
  input  logic [1:0]        mode,
  input  logic [FileW-1:0]  file_id,
  input  logic [PageW-1:0]  page_no,
  input  logic              set_dirty,
  output logic              done,
  output logic [1:0]        status,
  output logic [FrameW-1:0] frame,
  output logic              hit,
  output logic              need_read,
  output logic              write_back,
  output logic [FileW-1:0]  victim_file,
  output logic [PageW-1:0]  victim_page
);
  ctrl_t cmd;
  stat_t st;

  bfcr_ctrl u_ctrl (.clk, .rst, .start, .st, .busy, .cmd);

  bfcr_dp u_dp (
    .clk, .rst, .cmd, .st, .cfg_we, .cfg_data, .mode, .file_id, .page_no,
    .set_dirty, .done, .status, .frame, .hit, .need_read, .write_back,
    .victim_file, .victim_page
  );
endmodule

// File: rtl/bfcr_checker.sv
// Port-level checker for the frame replacer, bound to the top level
`include "buffer_frame_clock_replacer_macros.svh"
module bfcr_checker import bfcr_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic       done,
  input logic [1:0] status,
  input logic       hit,
  input logic       need_read,
  input logic       write_back
);
  `BFCR_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
  `BFCR_ASSERT_IMP(a_done_frees, done, !busy)
  `BFCR_ASSERT_IMP(a_read_miss, done && need_read, !hit && status == StatOk)
  `BFCR_ASSERT_IMP(a_wb_miss, done && write_back, !hit)
endmodule

bind buffer_frame_clock_replacer bfcr_checker u_chk (
  .clk, .rst, .start, .busy, .done, .status, .hit, .need_read, .write_back
);

// File: bench/testbench.sv
// Testbench for the clock replacement frame manager: random requests, predicted results
`timescale 1ns / 100ps
module testbench;
  import bfcr_pkg::*;

  typedef struct {
    logic [1:0]        status;
    logic [FrameW-1:0] frame;
    logic              hit;
    logic              need_read;
    logic              write_back;
    logic [FileW-1:0]  victim_file;
    logic [PageW-1:0]  victim_page;
  } reply_t;

  class frame_scoreboard;
    bit                valid[NumFrames];
    bit                refbit[NumFrames];
    bit                dirty[NumFrames];
    logic [PinBits-1:0] pins[NumFrames];
    logic [FileW-1:0]  pfile[NumFrames];
    logic [PageW-1:0]  ppage[NumFrames];
    int                hand;
    int                count;
    reply_t            awaited[$];
    int                errors;

    function void reset_state();
      for (int i = 0; i < NumFrames; i++) begin
        valid[i] = 0; refbit[i] = 0; dirty[i] = 0; pins[i] = '0;
        pfile[i] = '0; ppage[i] = '0;
      end
      count = NumFrames;
      hand = NumFrames - 1;
      awaited.delete();
      errors = 0;
    endfunction

    function void set_count(logic [CountW-1:0] v);
      count = v;
    endfunction

    function int span();
      if (count < 1) return 1;
      if (count > NumFrames) return NumFrames;
      return count;
    endfunction

    function void clear(int f);
      valid[f] = 0; refbit[f] = 0; dirty[f] = 0; pins[f] = '0;
      pfile[f] = '0; ppage[f] = '0;
    endfunction

    function void load(int f, logic [FileW-1:0] fid, logic [PageW-1:0] pno);
      valid[f] = 1; refbit[f] = 1; dirty[f] = 0; pins[f] = 1;
      pfile[f] = fid; ppage[f] = pno;
    endfunction

    // pick a frame by second chance; -1 when everything is pinned
    function int sweep(ref reply_t r);
      int n;
      n = span();
      for (int s = 0; s < 2 * n; s++) begin
        hand = (hand + 1) % n;
        if (!valid[hand]) return hand;
        if (refbit[hand]) begin
          refbit[hand] = 0;
          continue;
        end
        if (pins[hand] != 0) continue;
        if (dirty[hand]) begin
          r.write_back = 1;
          r.victim_file = pfile[hand];
          r.victim_page = ppage[hand];
        end
        clear(hand);
        return hand;
      end
      return -1;
    endfunction

    function void note_request(logic [1:0] m, logic [FileW-1:0] fid,
                               logic [PageW-1:0] pno, logic sd);
      reply_t r;
      int f, g;
      r = '{StatOk, '0, 0, 0, 0, '0, '0};
      f = -1;
      for (int i = 0; i < NumFrames; i++)
        if (f < 0 && valid[i] && pfile[i] == fid && ppage[i] == pno) f = i;
      case (m)
        ModeFetch: begin
          if (f >= 0) begin
            refbit[f] = 1;
            if (pins[f] != PinMax) pins[f]++;
            r.frame = f; r.hit = 1;
          end else begin
            g = sweep(r);
            if (g < 0) r.status = StatAllPinned;
            else begin
              load(g, fid, pno);
              r.frame = g; r.need_read = 1;
            end
          end
        end
        ModeUnpin: begin
          if (f < 0) r.status = StatNotRes;
          else begin
            r.frame = f; r.hit = 1;
            if (pins[f] == 0) r.status = StatNotPinned;
            else begin
              if (sd) dirty[f] = 1;
              pins[f]--;
            end
          end
        end
        ModeNew: begin
          if (f >= 0) begin
            load(f, fid, pno);
            r.frame = f; r.hit = 1;
          end else begin
            g = sweep(r);
            if (g < 0) r.status = StatAllPinned;
            else begin
              load(g, fid, pno);
              r.frame = g;
            end
          end
        end
        default: begin
          if (f >= 0) begin
            clear(f);
            r.frame = f; r.hit = 1;
          end
        end
      endcase
      awaited.push_back(r);
    endfunction

    function void check_result(reply_t got);
      reply_t e;
      if (awaited.size() == 0) begin
        $error("result with nothing outstanding");
        errors++;
        return;
      end
      e = awaited.pop_front();
      if (got.status !== e.status) begin
        $error("status: expected %0d, got %0d", e.status, got.status); errors++;
      end
      if (got.frame !== e.frame) begin
        $error("frame: expected %0d, got %0d", e.frame, got.frame); errors++;
      end
      if (got.hit !== e.hit) begin
        $error("hit: expected %0d, got %0d", e.hit, got.hit); errors++;
      end
      if (got.need_read !== e.need_read) begin
        $error("need_read: expected %0d, got %0d", e.need_read, got.need_read); errors++;
      end
      if (got.write_back !== e.write_back) begin
        $error("write_back: expected %0d, got %0d", e.write_back, got.write_back);
        errors++;
      end
      if (got.victim_file !== e.victim_file) begin
        $error("victim_file: expected %0h, got %0h", e.victim_file, got.victim_file);
        errors++;
      end
      if (got.victim_page !== e.victim_page) begin
        $error("victim_page: expected %0h, got %0h", e.victim_page, got.victim_page);
        errors++;
      end
    endfunction
  endclass

  logic              clk;
  logic              rst;
  logic              start;
  logic              busy;
  logic              cfg_we;
  logic [CountW-1:0] cfg_data;
  logic [1:0]        mode;
  logic [FileW-1:0]  file_id;
  logic [PageW-1:0]  page_no;
  logic              set_dirty;
  logic              done;
  logic [1:0]        status;
  logic [FrameW-1:0] frame;
  logic              hit;
  logic              need_read;
  logic              write_back;
  logic [FileW-1:0]  victim_file;
  logic [PageW-1:0]  victim_page;

  frame_scoreboard sb;
  int              quiet_cycles;
  logic [FileW-1:0] pool_file[16];
  logic [PageW-1:0] pool_page[16];

  localparam int WatchLimit = 3000;

  buffer_frame_clock_replacer dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .cfg_we(cfg_we), .cfg_data(cfg_data),
    .mode(mode), .file_id(file_id), .page_no(page_no), .set_dirty(set_dirty),
    .done(done), .status(status), .frame(frame), .hit(hit), .need_read(need_read),
    .write_back(write_back), .victim_file(victim_file), .victim_page(victim_page)
  );

  always begin
    clk = 1'b0; #4;
    clk = 1'b1; #4;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_we) sb.set_count(cfg_data);
      if (start && !busy) begin
        sb.note_request(mode, file_id, page_no, set_dirty);
      end
      if (done) begin
        sb.check_result('{status, frame, hit, need_read, write_back,
                          victim_file, victim_page});
      end
      if ((start && !busy) || done) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WatchLimit) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // present one word and hold it until taken; start stays high afterwards
  task automatic send(logic [1:0] m, logic [FileW-1:0] fid, logic [PageW-1:0] pno,
                      logic sd);
    @(posedge clk);
    start <= 1'b1;
    mode <= m; file_id <= fid; page_no <= pno; set_dirty <= sd;
    do @(posedge clk); while (busy);
  endtask

  task automatic pause();
    int g;
    g = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 3);
    if ($urandom_range(0, 3) == 0) g = 0;
    if (g > 0) begin
      start <= 1'b0;
      repeat (g - 1) @(posedge clk);
    end
  endtask

  task automatic drain();
    @(posedge clk);
    start <= 1'b0;
    while (sb.awaited.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic write_count(logic [CountW-1:0] v);
    drain();
    cfg_we <= 1'b1; cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic fill_pool();
    for (int i = 0; i < 16; i++) begin
      pool_file[i] = (i == 0) ? 8'h00 : (i == 1) ? 8'hFF : FileW'($urandom);
      pool_page[i] = (i == 0) ? 20'h00000 : (i == 2) ? 20'hFFFFF : PageW'($urandom);
    end
  endtask

  task automatic random_run(int n, int names);
    int k, sel;
    logic [1:0] m;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(0, names - 1);
      sel = $urandom_range(0, 99);
      m = (sel < 35) ? ModeFetch : (sel < 72) ? ModeUnpin : (sel < 85) ? ModeNew
                                                                       : ModeDispose;
      if ($urandom_range(0, 9) == 0)
        send(2'($urandom), FileW'($urandom), PageW'($urandom), 1'($urandom));
      else
        send(m, pool_file[k], pool_page[k], 1'($urandom));
      pause();
    end
  endtask

  initial begin
    sb = new();
    sb.reset_state();
    quiet_cycles = 0;
    rst = 1'b1; start = 1'b0; cfg_we = 1'b0; cfg_data = '0;
    mode = ModeFetch; file_id = '0; page_no = '0; set_dirty = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed: misses, hits, unpin cases, new page in place, dispose
    send(ModeFetch, 8'h00, 20'h00000, 1'b0);
    send(ModeFetch, 8'hFF, 20'hFFFFF, 1'b1);
    send(ModeFetch, 8'h00, 20'h00000, 1'b0);
    send(ModeUnpin, 8'h00, 20'h00000, 1'b1);
    send(ModeUnpin, 8'h00, 20'h00000, 1'b0);
    send(ModeUnpin, 8'h00, 20'h00000, 1'b0);
    send(ModeUnpin, 8'h12, 20'h34567, 1'b0);
    send(ModeNew, 8'hFF, 20'hFFFFF, 1'b0);
    send(ModeNew, 8'hA5, 20'h5A5A5, 1'b0);
    send(ModeDispose, 8'hA5, 20'h5A5A5, 1'b0);
    send(ModeDispose, 8'hA5, 20'h5A5A5, 1'b0);
    send(ModeDispose, 8'hFF, 20'hFFFFF, 1'b1);

    // two frames: fill, pin both, then dirty eviction
    write_count(6'd2);
    send(ModeFetch, 8'h01, 20'h00001, 1'b0);
    send(ModeFetch, 8'h02, 20'h00002, 1'b0);
    send(ModeFetch, 8'h03, 20'h00003, 1'b0);
    send(ModeUnpin, 8'h01, 20'h00001, 1'b1);
    send(ModeNew, 8'h04, 20'h00004, 1'b0);
    send(ModeNew, 8'h05, 20'h00005, 1'b0);

    // one frame: drive the pin count into saturation
    write_count(6'd1);
    send(ModeDispose, 8'h04, 20'h00004, 1'b0);
    send(ModeDispose, 8'h02, 20'h00002, 1'b0);
    send(ModeDispose, 8'h00, 20'h00000, 1'b0);
    for (int i = 0; i < 262; i++) send(ModeFetch, 8'h77, 20'h77777, 1'b0);
    for (int i = 0; i < 3; i++) send(ModeUnpin, 8'h77, 20'h77777, 1'b1);
    send(ModeDispose, 8'h77, 20'h77777, 1'b0);

    fill_pool(); write_count(6'd32); random_run(60, 16);
    fill_pool(); write_count(6'd4);  random_run(40, 8);
    fill_pool(); write_count(6'd0);  random_run(20, 4);
    fill_pool(); write_count(6'd63); random_run(50, 16);
    fill_pool(); write_count(6'd1);  random_run(20, 3);
    fill_pool(); write_count(6'd8);  random_run(45, 12);
    fill_pool(); write_count(6'd33); random_run(40, 16);

    drain();
    if (sb.errors == 0 && sb.awaited.size() == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end
endmodule
